// ===== sv/lzwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_pkg
// Constants, types and helpers shared by the LZW letter compressor files.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	// dictionary size, a power of two from 64 to 4096
	localparam int MAX_CODES    = 4096;
	// cells in the search chain, each owning one bank of the dictionary
	localparam int NCELL        = 32;
	localparam int CODE_W       = 12;
	localparam int LET_W        = 5;
	localparam int IDX_W        = $clog2(MAX_CODES);
	localparam int NFC_W        = IDX_W + 1;
	localparam int CELL_W       = $clog2(NCELL);
	localparam int BANK_DEPTH   = MAX_CODES / NCELL;
	localparam int BANK_W       = $clog2(BANK_DEPTH);
	localparam int FIRST_PHRASE = 27;
	localparam int LETTER_MAX   = 25;
	// cycles for a hit in the first cell to ripple to the end of the chain
	localparam int DRAIN_CYCLES = NCELL + 2;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

	// one dictionary entry: prefix code plus letter
	typedef struct packed {
		logic [IDX_W-1:0] pfx;
		logic [LET_W-1:0] ltr;
	} entry_t;

	// dictionary write, steered to one cell
	typedef struct packed {
		logic              en;
		logic [CELL_W-1:0] bank_sel;
		logic [BANK_W-1:0] addr;
		entry_t            data;
	} wr_t;

	// search control broadcast to every cell
	typedef struct packed {
		logic              clr;
		logic [BANK_W-1:0] rd_addr;
		logic              cmp_en;
		logic [BANK_W-1:0] cmp_addr;
		entry_t            key;
		logic [NFC_W-1:0]  nfc;
	} search_t;

	// match result handed from cell to cell
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] code;
	} chain_t;

	// clamp an input letter to the alphabet
	function automatic logic [LET_W-1:0] sat_letter(input logic [LET_W-1:0] l);
		return (l > LET_W'(LETTER_MAX)) ? LET_W'(LETTER_MAX) : l;
	endfunction

endpackage

// ===== sv/lzwc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_if
// Valid/ready channels for letter items and code items.
// ----------------------------------------------------------------------------
interface lzwc_letter_if;
	logic       valid;
	logic       ready;
	logic [4:0] letter;
	logic       final_letter;
	modport source (output valid, letter, final_letter, input ready);
	modport sink (input valid, letter, final_letter, output ready);
endinterface

interface lzwc_code_if;
	logic        valid;
	logic        ready;
	logic [11:0] code;
	logic        message_end;
	modport source (output valid, code, message_end, input ready);
	modport sink (input valid, code, message_end, output ready);
endinterface

// ===== sv/lzwc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_cell
// One search cell: a bank of dictionary entries, a compare against the key
// and a sticky match register passed on to the next cell.
// ----------------------------------------------------------------------------
module lzwc_cell import lzwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CELL_W-1:0] cell_id,
	input  search_t           srch,
	input  wr_t               wr,
	input  chain_t            chain_in,
	output chain_t            chain_out
);

	entry_t           bank_q [BANK_DEPTH];
	entry_t           rdata_q;
	chain_t           chain_q;
	logic [IDX_W-1:0] cmp_code;
	logic             hit;

	// bank write and registered read
	always_ff @(posedge clk) begin
		if (wr.en && wr.bank_sel == cell_id) begin
			bank_q[wr.addr] <= wr.data;
		end
		rdata_q <= bank_q[srch.rd_addr];
	end

	// the code of the entry read last cycle, and whether it matches a live entry
	assign cmp_code = {srch.cmp_addr, cell_id};
	assign hit = srch.cmp_en && (rdata_q == srch.key) &&
		(cmp_code >= IDX_W'(FIRST_PHRASE)) && ({1'b0, cmp_code} < srch.nfc);

	// sticky match, taken from upstream first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q.found <= 1'b0;
			chain_q.code  <= '0;
		end else if (srch.clr) begin
			chain_q.found <= 1'b0;
		end else if (!chain_q.found) begin
			if (chain_in.found) begin
				chain_q <= chain_in;
			end else if (hit) begin
				chain_q.found <= 1'b1;
				chain_q.code  <= cmp_code;
			end
		end
	end

	assign chain_out = chain_q;

endmodule

// ===== sv/lzw_letter_compressor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_letter_compressor_unit
// LZW compressor over A..Z with a dictionary searched by a chain of cells.
// ----------------------------------------------------------------------------
// letters (sink): one letter per item, final_letter marks the message end.
// codes (source): up to two code items per letter, message_end on the last.
// The first letter of a message only loads the prefix. Every later letter
// searches the dictionary: all NCELL cells read their bank in parallel,
// one address per cycle over the whole bank, then the match ripples down
// the chain while the block drains, before the result is resolved and
// emitted. A new letter is taken only once the previous one is fully done;
// ready is high only when idle.
// Results sit in an output register; a stalled receiver holds the block in
// its emit step with the code held stable until taken.
// Reset empties the dictionary (fill count back to 27) and drops the prefix;
// the banks themselves are not cleared, entries above the fill count are
// ignored by the compare.
// ----------------------------------------------------------------------------
module lzw_letter_compressor_unit import lzwc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	lzwc_letter_if.sink letters,
	lzwc_code_if.source codes
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SWEEP   = 6'b000010,
		ST_DRAIN   = 6'b000100,
		ST_RESOLVE = 6'b001000,
		ST_EMIT_A  = 6'b010000,
		ST_EMIT_B  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  prefix_q;
	logic              pv_q;
	logic [NFC_W-1:0]  nfc_q;
	logic [LET_W-1:0]  let_q;
	logic              last_q;
	logic              emit_a_q;
	logic [IDX_W-1:0]  emit_code_q;
	logic [BANK_W-1:0] addr_q;
	logic [DRAIN_W-1:0] drain_q;
	logic              cmp_en_s1;
	logic [BANK_W-1:0] cmp_addr_s1;
	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic              end_q;

	logic              accept;
	logic              out_free;
	logic              load_a;
	logic              load_b;
	logic [IDX_W-1:0]  let_code;
	search_t           srch;
	wr_t               wr;
	chain_t            chain [NCELL+1];

	assign accept   = letters.valid && letters.ready;
	assign out_free = !out_valid_q || codes.ready;
	assign load_a   = (state_q == ST_EMIT_A) && emit_a_q && out_free;
	assign load_b   = (state_q == ST_EMIT_B) && last_q && out_free;
	assign let_code = IDX_W'(let_q) + IDX_W'(1);

	// search control to the cells
	assign srch.clr      = accept && pv_q;
	assign srch.rd_addr  = addr_q;
	assign srch.cmp_en   = cmp_en_s1;
	assign srch.cmp_addr = cmp_addr_s1;
	assign srch.key.pfx  = prefix_q;
	assign srch.key.ltr  = let_q;
	assign srch.nfc      = nfc_q;

	// insert of a new phrase at the fill count
	assign wr.en       = (state_q == ST_RESOLVE) && !chain[NCELL].found &&
		(nfc_q < NFC_W'(MAX_CODES));
	assign wr.bank_sel = nfc_q[CELL_W-1:0];
	assign wr.addr     = nfc_q[IDX_W-1:CELL_W];
	assign wr.data.pfx = prefix_q;
	assign wr.data.ltr = let_q;

	// row of search cells
	assign chain[0] = '0;
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		lzwc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (CELL_W'(i)),
			.srch      (srch),
			.wr        (wr),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	// compare stage runs in the cycle after the bank read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= (state_q == ST_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		cmp_addr_s1 <= addr_q;
	end

	// output item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_a || load_b) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prefix_q <= '0;
			pv_q     <= 1'b0;
			nfc_q    <= NFC_W'(FIRST_PHRASE);
			emit_a_q <= 1'b0;
			addr_q   <= '0;
			drain_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (pv_q) begin
							addr_q  <= '0;
							state_q <= ST_SWEEP;
						end else begin
							prefix_q <= IDX_W'(sat_letter(letters.letter)) + IDX_W'(1);
							pv_q     <= 1'b1;
							emit_a_q <= 1'b0;
							state_q  <= ST_EMIT_A;
						end
					end
				end
				ST_SWEEP: begin
					addr_q <= addr_q + BANK_W'(1);
					if (addr_q == BANK_W'(BANK_DEPTH - 1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + DRAIN_W'(1);
					if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (chain[NCELL].found) begin
						prefix_q <= chain[NCELL].code;
						emit_a_q <= 1'b0;
					end else begin
						emit_code_q <= prefix_q;
						emit_a_q    <= 1'b1;
						prefix_q    <= let_code;
						if (wr.en) begin
							nfc_q <= nfc_q + NFC_W'(1);
						end
					end
					state_q <= ST_EMIT_A;
				end
				ST_EMIT_A: begin
					if (!emit_a_q) begin
						state_q <= ST_EMIT_B;
					end else if (out_free) begin
						state_q <= ST_EMIT_B;
					end
				end
				ST_EMIT_B: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pv_q    <= 1'b0;
						nfc_q   <= NFC_W'(FIRST_PHRASE);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			let_q  <= sat_letter(letters.letter);
			last_q <= letters.final_letter;
		end
		if (load_a) begin
			code_q <= CODE_W'(emit_code_q);
			end_q  <= 1'b0;
		end else if (load_b) begin
			code_q <= CODE_W'(prefix_q);
			end_q  <= 1'b1;
		end
	end

	assign letters.ready     = (state_q == ST_IDLE);
	assign codes.valid       = out_valid_q;
	assign codes.code        = code_q;
	assign codes.message_end = end_q;

endmodule

// ===== sv/lzwc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_checker
// Port-level checks on the LZW letter compressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] out_code,
	input logic        out_end
);

	// a code item stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("code item dropped while stalled");

	// a stalled code item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_code) && $stable(out_end))
		else $error("code item changed while stalled");

	// code zero is never emitted
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_code != 12'd0)
		else $error("zero code emitted");

	// one letter at a time
	a_one_letter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("letter taken while busy");

endmodule

bind lzw_letter_compressor_unit lzwc_checker u_lzwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (letters.valid),
	.in_ready  (letters.ready),
	.out_valid (codes.valid),
	.out_ready (codes.ready),
	.out_code  (codes.code),
	.out_end   (codes.message_end)
);
